// ===== hw/rtl/i2cm_pkg.sv =====
// i2cm_pkg: shared types, codes and helpers for the I2C master bit engine.
// Used by i2cm_seq, i2c_master_bit_engine and i2cm_checker. No dependencies.
`timescale 1ns / 1ps
package i2cm_pkg;

  localparam int unsigned TPU_W   = 10;   // ticks_per_us register width
  localparam int unsigned TMO_W   = 8;    // ack_timeout register width
  localparam int unsigned DLY_W   = 13;   // delay counter width
  localparam int unsigned PH_W    = 4;    // phase code width
  localparam int unsigned CFG_IX_W = 2;   // config register index width
  localparam int unsigned CFG_D_W  = 10;  // config write data width
  localparam int unsigned IN_D_W  = 16;   // in_tdata width
  localparam int unsigned IN_U_W  = 4;    // in_tuser width
  localparam int unsigned OUT_D_W = 16;   // out_tdata width

  localparam logic [TPU_W-1:0] TPU_RST = 10'd150;
  localparam logic [TMO_W-1:0] TMO_RST = 8'd250;

  // Configuration register indexes
  localparam logic [CFG_IX_W-1:0] CFG_TICKS_PER_US = 2'd0;
  localparam logic [CFG_IX_W-1:0] CFG_ACK_TIMEOUT  = 2'd1;

  // Command codes
  localparam logic [2:0] ACT_START = 3'd0;
  localparam logic [2:0] ACT_STOP  = 3'd1;
  localparam logic [2:0] ACT_WRITE = 3'd2;
  localparam logic [2:0] ACT_WACK  = 3'd3;
  localparam logic [2:0] ACT_READ  = 3'd4;

  // Sequencer phases
  localparam logic [PH_W-1:0] PH_IDLE  = 4'd0;
  localparam logic [PH_W-1:0] PH_S1    = 4'd1;
  localparam logic [PH_W-1:0] PH_S2    = 4'd2;
  localparam logic [PH_W-1:0] PH_P1    = 4'd3;
  localparam logic [PH_W-1:0] PH_P2    = 4'd4;
  localparam logic [PH_W-1:0] PH_WSET  = 4'd5;
  localparam logic [PH_W-1:0] PH_WHIGH = 4'd6;
  localparam logic [PH_W-1:0] PH_WLOW  = 4'd7;
  localparam logic [PH_W-1:0] PH_K1    = 4'd8;
  localparam logic [PH_W-1:0] PH_K2    = 4'd9;
  localparam logic [PH_W-1:0] PH_K3    = 4'd10;
  localparam logic [PH_W-1:0] PH_RLOW  = 4'd11;
  localparam logic [PH_W-1:0] PH_RHIGH = 4'd12;
  localparam logic [PH_W-1:0] PH_ALOW  = 4'd13;
  localparam logic [PH_W-1:0] PH_AHIGH = 4'd14;

  // Bus delays in microseconds
  localparam logic [2:0] US_1 = 3'd1;
  localparam logic [2:0] US_2 = 3'd2;
  localparam logic [2:0] US_5 = 3'd5;
  localparam logic [2:0] US_6 = 3'd6;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       ready_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_failed;
  } res_t;

  // Delay in ticks for a given microsecond count; never below one tick.
  // The microsecond count is a small constant, so this is shifts and adds.
  function automatic logic [DLY_W-1:0] delay_ticks(input logic [2:0] us,
                                                   input logic [TPU_W-1:0] tpu);
    logic [DLY_W-1:0] d;
    d = DLY_W'(us) * DLY_W'(tpu);
    return (d == '0) ? DLY_W'(1) : d;
  endfunction

endpackage

// ===== hw/rtl/i2cm_seq.sv =====
// i2cm_seq: I2C pin sequencer state and its one-tick next-state logic.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps
module i2cm_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,        // advance one tick
  input  logic [i2cm_pkg::TPU_W-1:0] ticks_per_us,
  input  logic [i2cm_pkg::TMO_W-1:0] ack_timeout,
  input  logic                       cmd_valid,
  input  logic [2:0]                 action,
  input  logic [7:0]                 tx_byte,
  input  logic                       send_ack,
  input  logic                       sda_in,
  output i2cm_pkg::res_t             res          // state after this tick
);

  logic [i2cm_pkg::PH_W-1:0]  phase_r, phase_nxt;
  logic [i2cm_pkg::DLY_W-1:0] delay_r, delay_nxt;
  logic [3:0]                 bit_r, bit_nxt;
  logic [7:0]                 shift_r, shift_nxt;
  logic [i2cm_pkg::TMO_W-1:0] wait_r, wait_nxt;
  logic                       ackc_r, ackc_nxt;
  logic                       scl_r, scl_nxt;
  logic                       sda_r, sda_nxt;
  logic                       drv_r, drv_nxt;
  logic [7:0]                 rx_r, rx_nxt;
  logic                       fail_r, fail_nxt;
  logic                       stopf_r, stopf_nxt;
  logic                       done;
  logic [3:0]                 bit_inc;
  logic [7:0]                 shift_sh;

  assign bit_inc  = bit_r + 4'd1;
  assign shift_sh = {shift_r[6:0], 1'b0};

  always_comb begin
    phase_nxt = phase_r;
    delay_nxt = delay_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    wait_nxt  = wait_r;
    ackc_nxt  = ackc_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    drv_nxt   = drv_r;
    rx_nxt    = rx_r;
    fail_nxt  = fail_r;
    stopf_nxt = stopf_r;
    done      = 1'b0;

    if (phase_r == i2cm_pkg::PH_IDLE) begin
      if (cmd_valid) begin
        unique case (action)
          i2cm_pkg::ACT_START: begin
            drv_nxt = 1'b1; sda_nxt = 1'b1; scl_nxt = 1'b1;
            delay_nxt = i2cm_pkg::delay_ticks(i2cm_pkg::US_5, ticks_per_us);
            phase_nxt = i2cm_pkg::PH_S1;
          end
          i2cm_pkg::ACT_STOP: begin
            drv_nxt = 1'b1; scl_nxt = 1'b1; sda_nxt = 1'b0; stopf_nxt = 1'b0;
            delay_nxt = i2cm_pkg::delay_ticks(i2cm_pkg::US_6, ticks_per_us);
            phase_nxt = i2cm_pkg::PH_P1;
          end
          i2cm_pkg::ACT_WRITE: begin
            drv_nxt = 1'b1; scl_nxt = 1'b0;
            shift_nxt = tx_byte; sda_nxt = tx_byte[7]; bit_nxt = 4'd0;
            delay_nxt = i2cm_pkg::delay_ticks(i2cm_pkg::US_2, ticks_per_us);
            phase_nxt = i2cm_pkg::PH_WSET;
          end
          i2cm_pkg::ACT_WACK: begin
            // direction is left alone until the first delay expires
            sda_nxt = 1'b1; wait_nxt = '0;
            delay_nxt = i2cm_pkg::delay_ticks(i2cm_pkg::US_1, ticks_per_us);
            phase_nxt = i2cm_pkg::PH_K1;
          end
          i2cm_pkg::ACT_READ: begin
            drv_nxt = 1'b0; scl_nxt = 1'b0;
            shift_nxt = '0; bit_nxt = 4'd0; ackc_nxt = send_ack;
            delay_nxt = i2cm_pkg::delay_ticks(i2cm_pkg::US_2, ticks_per_us);
            phase_nxt = i2cm_pkg::PH_RLOW;
          end
          default: ;  // unknown codes are dropped
        endcase
      end
    end else if (phase_r == i2cm_pkg::PH_K3) begin
      // poll SDA for the ack, one sample per tick
      if (!sda_in) begin
        scl_nxt = 1'b0; fail_nxt = 1'b0; phase_nxt = i2cm_pkg::PH_IDLE; done = 1'b1;
      end else if (wait_r >= ack_timeout) begin
        drv_nxt = 1'b1; scl_nxt = 1'b1; sda_nxt = 1'b0; stopf_nxt = 1'b1;
        delay_nxt = i2cm_pkg::delay_ticks(i2cm_pkg::US_6, ticks_per_us);
        phase_nxt = i2cm_pkg::PH_P1;
      end else begin
        wait_nxt = wait_r + 8'd1;
      end
    end else if (delay_r > i2cm_pkg::DLY_W'(1)) begin
      delay_nxt = delay_r - i2cm_pkg::DLY_W'(1);
    end else begin
      delay_nxt = '0;
      unique case (phase_r)
        i2cm_pkg::PH_S1: begin
          sda_nxt = 1'b0;
          delay_nxt = i2cm_pkg::delay_ticks(i2cm_pkg::US_6, ticks_per_us);
          phase_nxt = i2cm_pkg::PH_S2;
        end
        i2cm_pkg::PH_S2: begin
          scl_nxt = 1'b0; phase_nxt = i2cm_pkg::PH_IDLE; done = 1'b1;
        end
        i2cm_pkg::PH_P1: begin
          sda_nxt = 1'b1;
          delay_nxt = i2cm_pkg::delay_ticks(i2cm_pkg::US_6, ticks_per_us);
          phase_nxt = i2cm_pkg::PH_P2;
        end
        i2cm_pkg::PH_P2: begin
          if (stopf_r) fail_nxt = 1'b1;
          stopf_nxt = 1'b0; phase_nxt = i2cm_pkg::PH_IDLE; done = 1'b1;
        end
        i2cm_pkg::PH_WSET: begin
          scl_nxt = 1'b1;
          delay_nxt = i2cm_pkg::delay_ticks(i2cm_pkg::US_2, ticks_per_us);
          phase_nxt = i2cm_pkg::PH_WHIGH;
        end
        i2cm_pkg::PH_WHIGH: begin
          scl_nxt = 1'b0;
          delay_nxt = i2cm_pkg::delay_ticks(i2cm_pkg::US_2, ticks_per_us);
          phase_nxt = i2cm_pkg::PH_WLOW;
        end
        i2cm_pkg::PH_WLOW: begin
          bit_nxt = bit_inc;
          if (bit_inc >= i2cm_pkg::BITS_PER_BYTE) begin
            phase_nxt = i2cm_pkg::PH_IDLE; done = 1'b1;
          end else begin
            shift_nxt = shift_sh; sda_nxt = shift_sh[7];
            delay_nxt = i2cm_pkg::delay_ticks(i2cm_pkg::US_2, ticks_per_us);
            phase_nxt = i2cm_pkg::PH_WSET;
          end
        end
        i2cm_pkg::PH_K1: begin
          drv_nxt = 1'b0; scl_nxt = 1'b1;
          delay_nxt = i2cm_pkg::delay_ticks(i2cm_pkg::US_1, ticks_per_us);
          phase_nxt = i2cm_pkg::PH_K2;
        end
        i2cm_pkg::PH_K2: begin
          // first ack sample, then keep polling in the poll phase
          if (!sda_in) begin
            scl_nxt = 1'b0; fail_nxt = 1'b0; phase_nxt = i2cm_pkg::PH_IDLE; done = 1'b1;
          end else if (wait_r >= ack_timeout) begin
            drv_nxt = 1'b1; scl_nxt = 1'b1; sda_nxt = 1'b0; stopf_nxt = 1'b1;
            delay_nxt = i2cm_pkg::delay_ticks(i2cm_pkg::US_6, ticks_per_us);
            phase_nxt = i2cm_pkg::PH_P1;
          end else begin
            wait_nxt = wait_r + 8'd1; phase_nxt = i2cm_pkg::PH_K3;
          end
        end
        i2cm_pkg::PH_RLOW: begin
          scl_nxt = 1'b1; shift_nxt = {shift_r[6:0], sda_in};
          delay_nxt = i2cm_pkg::delay_ticks(i2cm_pkg::US_1, ticks_per_us);
          phase_nxt = i2cm_pkg::PH_RHIGH;
        end
        i2cm_pkg::PH_RHIGH: begin
          scl_nxt = 1'b0; bit_nxt = bit_inc;
          delay_nxt = i2cm_pkg::delay_ticks(i2cm_pkg::US_2, ticks_per_us);
          if (bit_inc < i2cm_pkg::BITS_PER_BYTE) begin
            phase_nxt = i2cm_pkg::PH_RLOW;
          end else begin
            rx_nxt = shift_r; drv_nxt = 1'b1; sda_nxt = !ackc_r;
            phase_nxt = i2cm_pkg::PH_ALOW;
          end
        end
        i2cm_pkg::PH_ALOW: begin
          scl_nxt = 1'b1;
          delay_nxt = i2cm_pkg::delay_ticks(i2cm_pkg::US_5, ticks_per_us);
          phase_nxt = i2cm_pkg::PH_AHIGH;
        end
        i2cm_pkg::PH_AHIGH: begin
          scl_nxt = 1'b0; phase_nxt = i2cm_pkg::PH_IDLE; done = 1'b1;
        end
        default: phase_nxt = i2cm_pkg::PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= i2cm_pkg::PH_IDLE;
      delay_r <= '0;
      bit_r   <= '0;
      shift_r <= '0;
      wait_r  <= '0;
      ackc_r  <= 1'b0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      drv_r   <= 1'b1;
      rx_r    <= '0;
      fail_r  <= 1'b0;
      stopf_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      delay_r <= delay_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      wait_r  <= wait_nxt;
      ackc_r  <= ackc_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      drv_r   <= drv_nxt;
      rx_r    <= rx_nxt;
      fail_r  <= fail_nxt;
      stopf_r <= stopf_nxt;
    end
  end

  always_comb begin
    res.scl_level  = scl_nxt;
    res.sda_level  = sda_nxt;
    res.sda_drive  = drv_nxt;
    res.ready_res  = (phase_nxt == i2cm_pkg::PH_IDLE);
    res.done_res   = done;
    res.rx_byte    = rx_nxt;
    res.ack_failed = fail_nxt;
  end

endmodule

// ===== hw/rtl/i2c_master_bit_engine.sv =====
// i2c_master_bit_engine: top level of the I2C master pin engine.
// Depends on i2cm_pkg and i2cm_seq.
`timescale 1ns / 1ps
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------
//  in_     | sink      | in_tvalid/in_tready   | one bus tick: command + SDA sample
//  out_    | source    | out_tvalid/out_tready | pin levels and status after the tick
//  cfg_    | sink      | cfg_valid/cfg_ready   | register write, index + data
//
//  One item per cycle unless the output stalls: each accepted item is one bus tick and runs
//  through the sequencer's next-state logic into the output register in the same cycle.
//  Every item yields exactly one result item, in the cycle after acceptance.
//  A stalled output holds the result; input is taken whenever the output
//  register is empty or being drained this cycle. cfg_ready is always high.
//  Synchronous active-low reset puts the pins at SCL high, SDA driven high.
module i2c_master_bit_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [7:0] tx_byte, [8] send_ack, [9] sda_in, [15:10] zero
  input  logic [i2cm_pkg::IN_D_W-1:0]   in_tdata,
  // [0] cmd_valid, [3:1] action
  input  logic [i2cm_pkg::IN_U_W-1:0]   in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [0] scl_level, [1] sda_level, [2] sda_drive, [3] ready_res, [4] done_res,
  // [12:5] rx_byte, [13] ack_failed, [15:14] zero
  output logic [i2cm_pkg::OUT_D_W-1:0]  out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [i2cm_pkg::CFG_IX_W-1:0] cfg_index,
  input  logic [i2cm_pkg::CFG_D_W-1:0]  cfg_data
);

  logic [i2cm_pkg::TPU_W-1:0] tpu_r;
  logic [i2cm_pkg::TMO_W-1:0] tmo_r;
  logic                       out_valid_r, out_valid_nxt;
  i2cm_pkg::res_t             res_r, res_nxt;
  logic                       step;

  assign cfg_ready = 1'b1;

  // Register writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpu_r <= i2cm_pkg::TPU_RST;
      tmo_r <= i2cm_pkg::TMO_RST;
    end else if (cfg_valid) begin
      if (cfg_index == i2cm_pkg::CFG_TICKS_PER_US) tpu_r <= cfg_data[i2cm_pkg::TPU_W-1:0];
      if (cfg_index == i2cm_pkg::CFG_ACK_TIMEOUT)  tmo_r <= cfg_data[i2cm_pkg::TMO_W-1:0];
    end
  end

  // Take a tick when the output register is free or drains this cycle.
  assign in_tready = !out_valid_r || out_tready;
  assign step      = in_tvalid && in_tready;

  i2cm_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .ticks_per_us (tpu_r),
    .ack_timeout  (tmo_r),
    .cmd_valid    (in_tuser[0]),
    .action       (in_tuser[3:1]),
    .tx_byte      (in_tdata[7:0]),
    .send_ack     (in_tdata[8]),
    .sda_in       (in_tdata[9]),
    .res          (res_nxt)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step)            out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload: load on every accepted tick, hold otherwise.
  always_ff @(posedge clk) begin
    if (step) res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r.ack_failed, res_r.rx_byte, res_r.done_res,
                       res_r.ready_res, res_r.sda_drive, res_r.sda_level, res_r.scl_level};

endmodule

// ===== hw/rtl/i2cm_checker.sv =====
// i2cm_checker: port-level assertions for i2c_master_bit_engine, bound in below.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps
module i2cm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [i2cm_pkg::OUT_D_W-1:0]  out_tdata
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Every accepted tick shows up as a result in the next cycle.
  a_tick_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted tick produced no result");

  // An empty output register never blocks the input.
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // A completing command always leaves the engine idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4] |-> out_tdata[3])
    else $error("done without ready");

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
